>>> rtl/rsqs_pkg.sv
// Shared types, constants and the degree sine table for the rotated sprite quad setup.
// No dependencies; every other file in rtl/ imports this package.
package rsqs_pkg;

    localparam int COORD_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int ALPHA_W   = 8;
    localparam int RGB_W     = 24;
    localparam int ARGB_W    = 32;
    localparam int TEX_W     = 16;
    localparam int UV_W      = 17;
    localparam int POS_W     = 24;
    localparam int SLOT_W    = 10;
    localparam int VIT_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Angle folding: (angle + DEG_BIAS) mod 360 by reciprocal multiply
    localparam int DEG_W      = 9;
    localparam int FOLD_W     = 17;
    localparam int FOLD_Q_W   = 8;
    localparam int DEG_FULL   = 360;
    localparam int DEG_QUARTER = 90;
    localparam int DEG_BIAS   = 36000;
    localparam int FOLD_MUL   = 186414;
    localparam int FOLD_MUL_W = 18;
    localparam int FOLD_SHIFT = 26;

    // Position rounding: Q14 offset to Q8, centre in whole pixels to Q8
    localparam int RND_BIAS     = 32;
    localparam int FRAC_SHIFT   = 6;
    localparam int CENTER_SHIFT = 8;
    localparam int SINE_W       = 16;

    localparam int VERT_IDX_W   = 3;
    localparam int VERT_LAST    = 5;
    localparam int TRI_SPLIT    = 3;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_U   = 2'd0,
        CFG_TEX_V   = 2'd1,
        CFG_TEX_EXT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [ARGB_W-1:0]         argb;
        logic                      full;
        logic [SLOT_W-1:0]         base;
    } quad_attr_t;

    typedef struct packed {
        quad_attr_t       attr;
        logic [DEG_W-1:0] deg;
    } quad_job_t;

    // Sine table for 0..90 degrees, Q1.14, built at elaboration by a Q30 series
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned TERM_DIV [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef logic [14:0] quarter_rom_t [DEG_QUARTER+1];

    function automatic int quarter_sine(int deg);
        longint unsigned x;
        longint unsigned t;
        longint          sum;
        longint          q;
        x = (longint'(deg) * PI_Q30 + 64'd90) / 64'd180;
        t = x;
        sum = longint'(x);
        for (int k = 1; k <= 12; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / TERM_DIV[k-1];
            if (k[0])
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        if (sum < 0)
            sum = 0;
        q = (sum + 64'sd32768) >>> 16;
        if (q > 16384)
            q = 16384;
        return int'(q);
    endfunction

    function automatic quarter_rom_t build_quarter_rom();
        quarter_rom_t rom;
        for (int d = 0; d <= DEG_QUARTER; d++)
        begin
            rom[d] = 15'(quarter_sine(d));
        end
        return rom;
    endfunction

    localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();

endpackage

>>> rtl/rsqs_front.sv
// Front end: accepts quads, folds the angle into 0..359 and books triangle slots.
// Depends on rsqs_pkg.
module rsqs_front #(
    parameter int TRIANGLE_CAPACITY = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [rsqs_pkg::COORD_W-1:0] center_x,
    input  logic signed [rsqs_pkg::COORD_W-1:0] center_y,
    input  logic signed [rsqs_pkg::ANGLE_W-1:0] angle_deg,
    input  logic [rsqs_pkg::ALPHA_W-1:0]      alpha,
    input  logic [rsqs_pkg::RGB_W-1:0]        rgb,
    output logic                              job_valid,
    input  logic                              job_stall,
    output rsqs_pkg::quad_job_t               job
);
    import rsqs_pkg::*;

    localparam int CNT_W = $clog2(TRIANGLE_CAPACITY + 1);

    logic                    a_valid_reg, a_valid_next;
    quad_attr_t              a_attr_reg;
    logic [FOLD_W-1:0]       a_n_reg;
    logic [FOLD_Q_W-1:0]     a_q_reg;
    logic                    b_valid_reg, b_valid_next;
    quad_job_t               b_job_reg;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic                    adv_b;
    logic                    accept;
    logic                    full;
    logic [FOLD_W-1:0]       n;
    logic [FOLD_W+FOLD_MUL_W-1:0] n_prod;
    logic [FOLD_W-1:0]       rem;
    quad_attr_t              attr;

    assign adv_b    = !b_valid_reg || !job_stall;
    assign in_stall = a_valid_reg && !adv_b;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        full = ({1'b0, count_reg} + (CNT_W+1)'(2))
               > (CNT_W+1)'(TRIANGLE_CAPACITY);
        n      = FOLD_W'(int'(angle_deg) + DEG_BIAS);
        n_prod = (FOLD_W+FOLD_MUL_W)'(n) * (FOLD_W+FOLD_MUL_W)'(FOLD_MUL);
        attr.cx   = center_x;
        attr.cy   = center_y;
        attr.argb = {alpha, rgb};
        attr.full = full;
        attr.base = full ? '0 : SLOT_W'(count_reg);
        count_next   = (accept && !full) ? count_reg + CNT_W'(2) : count_reg;
        a_valid_next = accept ? 1'b1 : (adv_b ? 1'b0 : a_valid_reg);
        b_valid_next = adv_b ? a_valid_reg : b_valid_reg;
        rem = a_n_reg - FOLD_W'(a_q_reg) * FOLD_W'(DEG_FULL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_attr_reg <= attr;
            a_n_reg    <= n;
            a_q_reg    <= n_prod[FOLD_SHIFT +: FOLD_Q_W];
        end
        if (adv_b)
        begin
            b_job_reg.attr <= a_attr_reg;
            b_job_reg.deg  <= rem[DEG_W-1:0];
        end
    end

    assign job_valid = b_valid_reg;
    assign job       = b_job_reg;

endmodule

>>> rtl/rsqs_queue.sv
// Two-entry queue of folded quad jobs between front and back end.
// Depends on rsqs_pkg.
module rsqs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_stall,
    input  rsqs_pkg::quad_job_t push_job,
    output logic                pop_valid,
    input  logic                pop,
    output rsqs_pkg::quad_job_t pop_job
);
    import rsqs_pkg::*;

    quad_job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]     fill_reg, fill_next;
    logic                     do_push, do_pop;

    assign push_stall = (fill_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop && pop_valid;
    assign pop_job    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QUEUE_PTR_W+1)'(do_push) - (QUEUE_PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> rtl/rsqs_back.sv
// Back end: looks up sine/cosine, walks the six vertices and rotates each corner.
// Depends on rsqs_pkg (types, constants, quarter sine table).
module rsqs_back #(
    parameter int HALF_LOW  = 64,
    parameter int HALF_HIGH = 63
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    output logic                                job_pop,
    input  rsqs_pkg::quad_job_t                 job,
    input  logic [rsqs_pkg::TEX_W-1:0]          tex_u_origin,
    input  logic [rsqs_pkg::TEX_W-1:0]          tex_v_origin,
    input  logic [rsqs_pkg::TEX_W-1:0]          tex_extent,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rsqs_pkg::POS_W-1:0]   pos_x,
    output logic signed [rsqs_pkg::POS_W-1:0]   pos_y,
    output logic [rsqs_pkg::UV_W-1:0]           vert_u,
    output logic [rsqs_pkg::UV_W-1:0]           vert_v,
    output logic [rsqs_pkg::ARGB_W-1:0]         argb,
    output logic [rsqs_pkg::SLOT_W-1:0]         triangle_slot,
    output logic [rsqs_pkg::VIT_W-1:0]          vertex_in_triangle,
    output logic                                buffer_full,
    output logic                                last
);
    import rsqs_pkg::*;

    localparam int HALF_MAX = (HALF_LOW > HALF_HIGH) ? HALF_LOW : HALF_HIGH;
    localparam int HW       = $clog2(HALF_MAX + 1) + 1;
    localparam int PROD_W   = HW + SINE_W;
    localparam int OFF_W    = PROD_W + 2;
    localparam int Q8_W     = OFF_W - FRAC_SHIFT;
    localparam int PW       = ((Q8_W > POS_W) ? Q8_W : POS_W) + 2;
    localparam logic signed [HW-1:0] LO = HW'(-HALF_LOW);
    localparam logic signed [HW-1:0] HI = HW'(HALF_HIGH);
    localparam logic signed [PW-1:0] P_MAX = PW'((2 ** (POS_W - 1)) - 1);
    localparam logic signed [PW-1:0] P_MIN = PW'(-(2 ** (POS_W - 1)));

    function automatic logic signed [SINE_W-1:0] sine_of(logic [DEG_W-1:0] deg);
        logic [DEG_W-1:0] idx;
        logic             neg;
        idx = deg;
        neg = 1'b0;
        if (deg <= DEG_W'(DEG_QUARTER))
            idx = deg;
        else if (deg <= DEG_W'(2 * DEG_QUARTER))
            idx = DEG_W'(2 * DEG_QUARTER) - deg;
        else if (deg < DEG_W'(3 * DEG_QUARTER))
        begin
            idx = deg - DEG_W'(2 * DEG_QUARTER);
            neg = 1'b1;
        end
        else
        begin
            idx = DEG_W'(DEG_FULL) - deg;
            neg = 1'b1;
        end
        sine_of = SINE_W'(QUARTER_ROM[idx[6:0]]);
        if (neg)
            sine_of = -sine_of;
    endfunction

    // Sequencer stage: the quad being walked
    logic                     s_valid_reg, s_valid_next;
    quad_attr_t               s_attr_reg;
    logic signed [SINE_W-1:0] s_sin_reg, s_cos_reg;
    logic [VERT_IDX_W-1:0]    s_k_reg, s_k_next;

    // Product stage
    logic                     m_valid_reg, m_valid_next;
    logic signed [PROD_W-1:0] m_lxc_reg, m_lys_reg, m_lxs_reg, m_lyc_reg;
    logic signed [COORD_W-1:0] m_cx_reg, m_cy_reg;
    logic [UV_W-1:0]          m_u_reg, m_v_reg;
    logic [ARGB_W-1:0]        m_argb_reg;
    logic [SLOT_W-1:0]        m_slot_reg;
    logic [VIT_W-1:0]         m_vit_reg;
    logic                     m_full_reg, m_last_reg;

    // Output stage
    logic                     o_valid_reg, o_valid_next;
    logic signed [POS_W-1:0]  o_x_reg, o_y_reg;
    logic [UV_W-1:0]          o_u_reg, o_v_reg;
    logic [ARGB_W-1:0]        o_argb_reg;
    logic [SLOT_W-1:0]        o_slot_reg;
    logic [VIT_W-1:0]         o_vit_reg;
    logic                     o_full_reg, o_last_reg;

    logic                     adv, issue, done, load;
    logic [DEG_W:0]           cos_sum;
    logic [DEG_W-1:0]         cos_deg;
    logic [1:0]               corner;
    logic                     x_hi, y_hi, second;
    logic signed [HW-1:0]     lx, ly;
    logic [UV_W-1:0]          u_far, v_far;
    logic signed [OFF_W-1:0]  off_x, off_y;
    logic signed [Q8_W-1:0]   q8_x, q8_y;
    logic signed [PW-1:0]     p_x, p_y;
    logic signed [POS_W-1:0]  sat_x, sat_y;

    assign adv     = !o_valid_reg || !out_stall;
    assign issue   = s_valid_reg && adv;
    assign done    = issue && (s_k_reg == VERT_IDX_W'(VERT_LAST));
    assign load    = job_valid && (!s_valid_reg || done);
    assign job_pop = load;

    always_comb
    begin
        cos_sum = (DEG_W+1)'(job.deg) + (DEG_W+1)'(DEG_QUARTER);
        if (cos_sum >= (DEG_W+1)'(DEG_FULL))
            cos_sum = cos_sum - (DEG_W+1)'(DEG_FULL);
        cos_deg = cos_sum[DEG_W-1:0];

        // Vertex order V0 V1 V2, V2 V3 V0
        case (s_k_reg)
            3'd0:    corner = 2'd0;
            3'd1:    corner = 2'd1;
            3'd2:    corner = 2'd2;
            3'd3:    corner = 2'd2;
            3'd4:    corner = 2'd3;
            default: corner = 2'd0;
        endcase
        x_hi   = (corner == 2'd1) || (corner == 2'd2);
        y_hi   = (corner == 2'd2) || (corner == 2'd3);
        lx     = x_hi ? HI : LO;
        ly     = y_hi ? HI : LO;
        second = (s_k_reg >= VERT_IDX_W'(TRI_SPLIT));
        u_far  = UV_W'(tex_u_origin) + UV_W'(tex_extent);
        v_far  = UV_W'(tex_v_origin) + UV_W'(tex_extent);

        s_valid_next = load ? 1'b1 : (done ? 1'b0 : s_valid_reg);
        s_k_next     = load ? '0 : (issue ? s_k_reg + 1'b1 : s_k_reg);
        m_valid_next = adv ? s_valid_reg : m_valid_reg;
        o_valid_next = adv ? m_valid_reg : o_valid_reg;

        // Round Q14 to Q8, add centre, clamp to 24 bits
        off_x = OFF_W'(m_lxc_reg) + OFF_W'(m_lys_reg) + OFF_W'(RND_BIAS);
        off_y = OFF_W'(m_lyc_reg) - OFF_W'(m_lxs_reg) + OFF_W'(RND_BIAS);
        q8_x  = Q8_W'(off_x >>> FRAC_SHIFT);
        q8_y  = Q8_W'(off_y >>> FRAC_SHIFT);
        p_x   = (PW'(m_cx_reg) <<< CENTER_SHIFT) + PW'(q8_x);
        p_y   = (PW'(m_cy_reg) <<< CENTER_SHIFT) + PW'(q8_y);
        if (p_x > P_MAX)
            sat_x = POS_W'(P_MAX);
        else if (p_x < P_MIN)
            sat_x = POS_W'(P_MIN);
        else
            sat_x = POS_W'(p_x);
        if (p_y > P_MAX)
            sat_y = POS_W'(P_MAX);
        else if (p_y < P_MIN)
            sat_y = POS_W'(P_MIN);
        else
            sat_y = POS_W'(p_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            s_k_reg     <= '0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            s_k_reg     <= s_k_next;
            m_valid_reg <= m_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s_attr_reg <= job.attr;
            s_sin_reg  <= sine_of(job.deg);
            s_cos_reg  <= sine_of(cos_deg);
        end
        if (adv)
        begin
            m_lxc_reg  <= PROD_W'(lx) * PROD_W'(s_cos_reg);
            m_lys_reg  <= PROD_W'(ly) * PROD_W'(s_sin_reg);
            m_lxs_reg  <= PROD_W'(lx) * PROD_W'(s_sin_reg);
            m_lyc_reg  <= PROD_W'(ly) * PROD_W'(s_cos_reg);
            m_cx_reg   <= s_attr_reg.cx;
            m_cy_reg   <= s_attr_reg.cy;
            m_u_reg    <= x_hi ? u_far : UV_W'(tex_u_origin);
            m_v_reg    <= y_hi ? v_far : UV_W'(tex_v_origin);
            m_argb_reg <= s_attr_reg.argb;
            m_slot_reg <= s_attr_reg.full ? '0 : s_attr_reg.base + SLOT_W'(second);
            m_vit_reg  <= second ? VIT_W'(s_k_reg - VERT_IDX_W'(TRI_SPLIT))
                                 : VIT_W'(s_k_reg);
            m_full_reg <= s_attr_reg.full;
            m_last_reg <= (s_k_reg == VERT_IDX_W'(VERT_LAST));

            o_x_reg    <= sat_x;
            o_y_reg    <= sat_y;
            o_u_reg    <= m_u_reg;
            o_v_reg    <= m_v_reg;
            o_argb_reg <= m_argb_reg;
            o_slot_reg <= m_slot_reg;
            o_vit_reg  <= m_vit_reg;
            o_full_reg <= m_full_reg;
            o_last_reg <= m_last_reg;
        end
    end

    assign out_valid          = o_valid_reg;
    assign pos_x              = o_x_reg;
    assign pos_y              = o_y_reg;
    assign vert_u             = o_u_reg;
    assign vert_v             = o_v_reg;
    assign argb               = o_argb_reg;
    assign triangle_slot      = o_slot_reg;
    assign vertex_in_triangle = o_vit_reg;
    assign buffer_full        = o_full_reg;
    assign last               = o_last_reg;

endmodule

>>> rtl/rotated_sprite_quad_setup_core.sv
// Top level of the rotated sprite quad setup: texture registers, front end, queue, back end.
// Depends on rsqs_pkg, rsqs_front, rsqs_queue and rsqs_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   in      | input     | in_valid/in_stall  | center_x center_y angle_deg alpha rgb
//   out     | output    | out_valid/out_stall| pos_x pos_y vert_u vert_v argb triangle_slot
//           |           |                    | vertex_in_triangle buffer_full last
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index cfg_data
//
// Each item yields six vertex results, one per cycle while out is not stalled; the back end's
// vertex sequencer loads the next item in the same cycle as it issues the last vertex.
// From accept to the first vertex an item passes two fold stages, the queue, the
// sequencer, the product stage and the output register.
// Reset clears all valid flags, the queue and the triangle counter; the sine table is
// constant and needs no clearing pass. cfg_ready is always high.
// A stall on out holds the output register and freezes the back end; the two-entry queue
// lets the front keep accepting items until it fills.
module rotated_sprite_quad_setup_core #(
    parameter int TRIANGLE_CAPACITY = 1024,
    parameter int HALF_LOW          = 64,
    parameter int HALF_HIGH         = 63
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rsqs_pkg::COORD_W-1:0]  center_x,
    input  logic signed [rsqs_pkg::COORD_W-1:0]  center_y,
    input  logic signed [rsqs_pkg::ANGLE_W-1:0]  angle_deg,
    input  logic [rsqs_pkg::ALPHA_W-1:0]         alpha,
    input  logic [rsqs_pkg::RGB_W-1:0]           rgb,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rsqs_pkg::POS_W-1:0]    pos_x,
    output logic signed [rsqs_pkg::POS_W-1:0]    pos_y,
    output logic [rsqs_pkg::UV_W-1:0]            vert_u,
    output logic [rsqs_pkg::UV_W-1:0]            vert_v,
    output logic [rsqs_pkg::ARGB_W-1:0]          argb,
    output logic [rsqs_pkg::SLOT_W-1:0]          triangle_slot,
    output logic [rsqs_pkg::VIT_W-1:0]           vertex_in_triangle,
    output logic                                 buffer_full,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rsqs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsqs_pkg::TEX_W-1:0]           cfg_data
);
    import rsqs_pkg::*;

    logic [TEX_W-1:0] tex_u_reg, tex_u_next;
    logic [TEX_W-1:0] tex_v_reg, tex_v_next;
    logic [TEX_W-1:0] tex_ext_reg, tex_ext_next;

    logic       fe_valid, fe_stall;
    quad_job_t  fe_job;
    logic       q_valid, q_pop;
    quad_job_t  q_job;

    assign cfg_ready = 1'b1;

    // Register writes: drop indexes beyond the list
    always_comb
    begin
        tex_u_next   = tex_u_reg;
        tex_v_next   = tex_v_reg;
        tex_ext_next = tex_ext_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEX_U:   tex_u_next   = cfg_data;
                CFG_TEX_V:   tex_v_next   = cfg_data;
                CFG_TEX_EXT: tex_ext_next = cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_u_reg   <= '0;
            tex_v_reg   <= '0;
            tex_ext_reg <= '0;
        end
        else
        begin
            tex_u_reg   <= tex_u_next;
            tex_v_reg   <= tex_v_next;
            tex_ext_reg <= tex_ext_next;
        end
    end

    // Front end: fold the angle, book slots
    rsqs_front #(
        .TRIANGLE_CAPACITY (TRIANGLE_CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .center_x  (center_x),
        .center_y  (center_y),
        .angle_deg (angle_deg),
        .alpha     (alpha),
        .rgb       (rgb),
        .job_valid (fe_valid),
        .job_stall (fe_stall),
        .job       (fe_job)
    );

    // Decouple front and back so each side stalls on its own
    rsqs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_stall (fe_stall),
        .push_job   (fe_job),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_job    (q_job)
    );

    // Back end: rotate corners, emit six vertices
    rsqs_back #(
        .HALF_LOW  (HALF_LOW),
        .HALF_HIGH (HALF_HIGH)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .job_valid          (q_valid),
        .job_pop            (q_pop),
        .job                (q_job),
        .tex_u_origin       (tex_u_reg),
        .tex_v_origin       (tex_v_reg),
        .tex_extent         (tex_ext_reg),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .pos_x              (pos_x),
        .pos_y              (pos_y),
        .vert_u             (vert_u),
        .vert_v             (vert_v),
        .argb               (argb),
        .triangle_slot      (triangle_slot),
        .vertex_in_triangle (vertex_in_triangle),
        .buffer_full        (buffer_full),
        .last               (last)
    );

endmodule
